>>> rtl/core/ssg_pkg.sv
// ssg_pkg: shared types and codes for the stepper ramp step generator
// holds action codes, register indexes, error codes and the request/result structs
// no dependencies
package ssg_pkg;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_MOVE    = 3'd1,
        ACT_MANUAL  = 3'd2,
        ACT_STOP    = 3'd3,
        ACT_REFRESH = 3'd4,
        ACT_CLEAR   = 3'd5,
        ACT_ZERO    = 3'd6
    } action_t;

    localparam logic [2:0] CFG_START_PERIOD    = 3'd0;
    localparam logic [2:0] CFG_CRUISE_PERIOD   = 3'd1;
    localparam logic [2:0] CFG_MS_PER_STEP     = 3'd2;
    localparam logic [2:0] CFG_TARGET_STEPS    = 3'd3;
    localparam logic [2:0] CFG_UNDERSTEP       = 3'd4;
    localparam logic [2:0] CFG_OVERSTEP        = 3'd5;
    localparam logic [2:0] CFG_DISTANCE_ENABLE = 3'd6;
    localparam logic [2:0] CFG_FREE_STAY       = 3'd7;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERSTEP = 2'd1;
    localparam logic [1:0] ERR_OVERSTEP  = 2'd2;

    localparam logic [15:0] START_PERIOD_RST  = 16'd1000;
    localparam logic [15:0] CRUISE_PERIOD_RST = 16'd100;
    localparam logic [15:0] MS_PER_STEP_RST   = 16'd1;
    localparam logic [15:0] PERIOD_MAX        = 16'hFFFF;
    localparam logic [15:0] TIMER_RST         = 16'd1;

    typedef struct packed {
        logic [15:0] start_period;
        logic [15:0] cruise_period;
        logic [15:0] ms_per_period_step;
        logic [31:0] target_steps;
        logic [31:0] understep_margin;
        logic [31:0] overstep_margin;
        logic        distance_enable;
        logic        free_stay;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic        direction;
        logic [1:0]  endstop;
        logic        ramp_stop;
        logic [31:0] time_ms;
        logic [15:0] manual_period;
    } request_t;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic        enable_level;
        logic        finished;
        logic        moving;
        logic [1:0]  error_code;
        logic [31:0] step_count;
        logic [31:0] position;
        logic [15:0] period_now;
    } result_t;

endpackage

>>> rtl/core/ssg_cfg_regs.sv
// ssg_cfg_regs: configuration register file written through the plain write port
// depends on ssg_pkg for cfg_t and register indexes
module ssg_cfg_regs
    import ssg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_PERIOD:    cfg_next.start_period       = cfg_wdata[15:0];
                CFG_CRUISE_PERIOD:   cfg_next.cruise_period      = cfg_wdata[15:0];
                CFG_MS_PER_STEP:     cfg_next.ms_per_period_step = cfg_wdata[15:0];
                CFG_TARGET_STEPS:    cfg_next.target_steps       = cfg_wdata;
                CFG_UNDERSTEP:       cfg_next.understep_margin   = cfg_wdata;
                CFG_OVERSTEP:        cfg_next.overstep_margin    = cfg_wdata;
                CFG_DISTANCE_ENABLE: cfg_next.distance_enable    = cfg_wdata[0];
                CFG_FREE_STAY:       cfg_next.free_stay          = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_period       <= START_PERIOD_RST;
            cfg_reg.cruise_period      <= CRUISE_PERIOD_RST;
            cfg_reg.ms_per_period_step <= MS_PER_STEP_RST;
            cfg_reg.target_steps       <= '0;
            cfg_reg.understep_margin   <= '0;
            cfg_reg.overstep_margin    <= '0;
            cfg_reg.distance_enable    <= 1'b1;
            cfg_reg.free_stay          <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/ssg_engine.sv
// ssg_engine: motor state registers and the single-pass update for one request
// depends on ssg_pkg for cfg_t, request_t, result_t and codes
module ssg_engine
    import ssg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     fire,
    input  request_t req,
    input  cfg_t     cfg,
    output result_t  result
);

    typedef struct packed {
        logic        step_line;
        logic        dir_line;
        logic        enable_line;
        logic        moving;
        logic        stopped;
        logic        finished;
        logic        manual;
        logic        brake;
        logic [1:0]  error_state;
        logic [15:0] tick_timer;
        logic [15:0] period;
        logic [31:0] half_steps;
        logic [31:0] position;
        logic [31:0] accel_end;
        logic [31:0] last_ramp_ms;
    } state_t;

    state_t      st_reg;
    state_t      st_next;
    logic        fin;
    logic        done;
    logic [31:0] under_limit;
    logic [31:0] decel_from;
    logic [32:0] over_limit;
    logic [32:0] ramp_due_at;
    logic        ramp_due;

    // limits that depend on configuration and stored state, and the ramp check against the request time
    assign under_limit = (cfg.understep_margin > cfg.target_steps) ? '0
                         : cfg.target_steps - cfg.understep_margin;
    assign decel_from  = (st_reg.accel_end > cfg.target_steps) ? '0
                         : cfg.target_steps - st_reg.accel_end;
    assign over_limit  = {1'b0, cfg.target_steps} + {1'b0, cfg.overstep_margin};
    assign ramp_due_at = {1'b0, st_reg.last_ramp_ms} + {17'b0, cfg.ms_per_period_step};
    assign ramp_due    = {1'b0, req.time_ms} >= ramp_due_at;

    always_comb begin
        st_next = st_reg;
        fin     = st_reg.finished;
        done    = 1'b0;
        case (req.action)
            ACT_TICK: begin
                if (!st_reg.moving) begin
                    st_next.tick_timer = TIMER_RST;
                end else if (st_reg.period != '0) begin
                    if (st_reg.tick_timer >= st_reg.period) begin
                        st_next.step_line  = ~st_reg.step_line;
                        st_next.half_steps = st_reg.half_steps + 32'd1;
                        st_next.position   = st_reg.dir_line ? st_reg.position + 32'd1
                                                             : st_reg.position - 32'd1;
                        st_next.tick_timer = TIMER_RST;
                    end else begin
                        st_next.tick_timer = st_reg.tick_timer + 16'd1;
                    end
                end
            end
            ACT_MOVE: begin
                if (st_reg.manual || st_reg.stopped || st_reg.error_state != ERR_NONE) begin
                    fin = 1'b0;
                end else if (st_reg.finished) begin
                    fin = 1'b1;
                end else begin
                    fin = 1'b0;
                    // end stop hit (codes two and three)
                    if (req.endstop[1]) begin
                        if (cfg.distance_enable && st_reg.half_steps < under_limit) begin
                            st_next.moving      = 1'b0;
                            st_next.stopped     = 1'b1;
                            st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                            st_next.error_state = ERR_UNDERSTEP;
                            done                = 1'b1;
                        end else if (req.ramp_stop) begin
                            st_next.brake = 1'b1;
                            if (st_reg.period > cfg.start_period) begin
                                st_next.moving      = 1'b0;
                                st_next.stopped     = 1'b1;
                                st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                                st_next.brake       = 1'b0;
                                st_next.finished    = 1'b1;
                                fin                 = 1'b1;
                                done                = 1'b1;
                            end
                        end else begin
                            st_next.moving      = 1'b0;
                            st_next.stopped     = 1'b1;
                            st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                            st_next.finished    = 1'b1;
                            fin                 = 1'b1;
                            done                = 1'b1;
                        end
                    end
                    if (!done && cfg.distance_enable) begin
                        if (st_reg.half_steps >= cfg.target_steps && req.endstop == 2'd0) begin
                            st_next.moving      = 1'b0;
                            st_next.stopped     = 1'b1;
                            st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                            st_next.finished    = 1'b1;
                            fin                 = 1'b1;
                            done                = 1'b1;
                        end else if ({1'b0, st_reg.half_steps} >= over_limit) begin
                            st_next.moving      = 1'b0;
                            st_next.stopped     = 1'b1;
                            st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                            st_next.error_state = ERR_OVERSTEP;
                            done                = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (!st_reg.moving) begin
                            st_next.dir_line    = req.direction;
                            st_next.enable_line = 1'b0;
                            st_next.period      = cfg.start_period;
                            st_next.moving      = 1'b1;
                        end
                        if (ramp_due) begin
                            if (st_next.period > cfg.cruise_period &&
                                (!cfg.distance_enable ||
                                 st_reg.half_steps < (cfg.target_steps >> 1)) &&
                                !st_next.brake) begin
                                st_next.period    = st_next.period - 16'd1;
                                st_next.accel_end = st_reg.half_steps;
                            end else if ((st_next.period < cfg.start_period &&
                                          st_reg.half_steps > decel_from &&
                                          cfg.distance_enable) || st_next.brake) begin
                                if (st_next.period != PERIOD_MAX) begin
                                    st_next.period = st_next.period + 16'd1;
                                end
                            end
                        end
                        // time going backward pulls the ramp mark along
                        if (ramp_due || st_reg.last_ramp_ms > req.time_ms) begin
                            st_next.last_ramp_ms = req.time_ms;
                        end
                    end
                end
            end
            ACT_MANUAL: begin
                st_next.manual      = 1'b1;
                st_next.moving      = 1'b1;
                st_next.dir_line    = req.direction;
                st_next.enable_line = 1'b0;
                st_next.period      = req.manual_period;
            end
            ACT_STOP: begin
                st_next.moving      = 1'b0;
                st_next.stopped     = 1'b1;
                st_next.enable_line = st_reg.enable_line | cfg.free_stay;
            end
            ACT_REFRESH: begin
                st_next.moving      = 1'b0;
                st_next.stopped     = 1'b0;
                st_next.enable_line = st_reg.enable_line | cfg.free_stay;
                st_next.finished    = 1'b0;
                st_next.manual      = 1'b0;
                st_next.brake       = 1'b0;
                st_next.half_steps  = '0;
                fin                 = 1'b0;
            end
            ACT_CLEAR: begin
                st_next.error_state = ERR_NONE;
            end
            ACT_ZERO: begin
                st_next.position = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.step_line    <= 1'b0;
            st_reg.dir_line     <= 1'b0;
            st_reg.enable_line  <= 1'b0;
            st_reg.moving       <= 1'b0;
            st_reg.stopped      <= 1'b0;
            st_reg.finished     <= 1'b0;
            st_reg.manual       <= 1'b0;
            st_reg.brake        <= 1'b0;
            st_reg.error_state  <= ERR_NONE;
            st_reg.tick_timer   <= TIMER_RST;
            st_reg.period       <= '0;
            st_reg.half_steps   <= '0;
            st_reg.position     <= '0;
            st_reg.accel_end    <= '0;
            st_reg.last_ramp_ms <= '0;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        result.step_level   = st_next.step_line;
        result.dir_level    = st_next.dir_line;
        result.enable_level = st_next.enable_line;
        result.finished     = fin;
        result.moving       = st_next.moving;
        result.error_code   = st_next.error_state;
        result.step_count   = st_next.half_steps;
        result.position     = st_next.position;
        result.period_now   = st_next.period;
    end

endmodule

>>> rtl/core/ssg_out_stage.sv
// ssg_out_stage: result register with its valid flag on the m_ side
// depends on ssg_pkg for result_t
module ssg_out_stage
    import ssg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result_in,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

>>> rtl/core/stepper_ramp_step_generator.sv
// stepper_ramp_step_generator: top level with request register, engine and result register
// depends on ssg_pkg, ssg_cfg_regs, ssg_engine and ssg_out_stage
//
// Single-axis stepper step generator with a trapezoidal ramp. Each request (tick, move,
// manual, stop, refresh, clear error, zero position) gives exactly one result that shows
// the step, direction and enable lines, the finished verdict, moving flag, error code,
// half-step count, signed position and current period. Throughput is one request per
// clock unless m_ready stalls the result register; a request passes through the request
// register and then the result register. The rate holds as the motor state update is
// combinational, so the next request sees it at once. One further request is taken while
// a result still waits on m_ready; then s_ready stays low until that result leaves.
// No clearing pass runs after reset. The user must write configuration through cfg_wr_en/
// cfg_index/cfg_wdata only while no request is in flight; the block does not enforce it.
module stepper_ramp_step_generator
    import ssg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic        s_direction,
    input  logic [1:0]  s_endstop,
    input  logic        s_ramp_stop,
    input  logic [31:0] s_time_ms,
    input  logic [15:0] s_manual_period,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_step_level,
    output logic        m_dir_level,
    output logic        m_enable_level,
    output logic        m_finished,
    output logic        m_moving,
    output logic [1:0]  m_error_code,
    output logic [31:0] m_step_count,
    output logic signed [31:0] m_position,
    output logic [15:0] m_period_now
);

    cfg_t     cfg;
    request_t req_reg;
    logic     req_valid_reg;
    logic     req_valid_next;
    logic     advance;
    logic     fire;
    result_t  eng_result;
    result_t  out_result;

    // the request moves on when the result register is free or being emptied
    assign advance = !m_valid || m_ready;
    assign fire    = req_valid_reg && advance;
    assign s_ready = !req_valid_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end else if (fire) begin
            req_valid_next = 1'b0;
        end else begin
            req_valid_next = req_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.action        <= action_t'(s_action);
            req_reg.direction     <= s_direction;
            req_reg.endstop       <= s_endstop;
            req_reg.ramp_stop     <= s_ramp_stop;
            req_reg.time_ms       <= s_time_ms;
            req_reg.manual_period <= s_manual_period;
        end
    end

    ssg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssg_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (req_reg),
        .cfg     (cfg),
        .result  (eng_result)
    );

    ssg_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .result_in  (eng_result),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result_out (out_result)
    );

    assign m_step_level   = out_result.step_level;
    assign m_dir_level    = out_result.dir_level;
    assign m_enable_level = out_result.enable_level;
    assign m_finished     = out_result.finished;
    assign m_moving       = out_result.moving;
    assign m_error_code   = out_result.error_code;
    assign m_step_count   = out_result.step_count;
    assign m_position     = signed'(out_result.position);
    assign m_period_now   = out_result.period_now;

endmodule

>>> rtl/core/ssg_checker.sv
// ssg_checker: port-level assertions for the stepper ramp step generator
// bound to stepper_ramp_step_generator; no package dependencies
module ssg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_enable_level,
    input logic        m_moving,
    input logic [1:0]  m_error_code,
    input logic [31:0] m_step_count,
    input logic signed [31:0] m_position
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_count) && $stable(m_position))
        else $error("result changed while stalled");

    // with the result register empty a request can always be taken
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused with empty result register");

    // a moving motor always has its driver enabled
    a_moving_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_moving |-> !m_enable_level)
        else $error("motor moving with driver released");

    // only the none, understep and overstep codes are reported
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code != 2'd3)
        else $error("unknown error code");

endmodule

bind stepper_ramp_step_generator ssg_checker u_ssg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_enable_level (m_enable_level),
    .m_moving       (m_moving),
    .m_error_code   (m_error_code),
    .m_step_count   (m_step_count),
    .m_position     (m_position)
);

>>> test/stepper_ramp_step_generator_tb.sv
// stepper_ramp_step_generator_tb: self-checking bench for the stepper ramp step generator
// a scoreboard class predicts every result from its own motor state; tasks drive requests,
// register writes and a stalling result sink. depends on ssg_pkg and the block itself
module stepper_ramp_step_generator_tb;
    import ssg_pkg::*;

    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int STALL_LIMIT     = 4000;

    class ramp_scoreboard;
        logic [15:0] start_p, cruise_p, ms_step;
        logic [31:0] target, under_m, over_m;
        logic        dist_en, release_idle;

        logic        step_q, dir_q, en_q, moving_q, stopped_q, done_q, manual_q, brake_q;
        logic [1:0]  err_q;
        logic [15:0] timer_q, period_q;
        logic [31:0] half_q, pos_q, accel_mark, ramp_ms;

        result_t expected_q[$];
        int errors, n_requests, n_checked, n_done, n_under, n_over;

        function void reset_all();
            start_p = START_PERIOD_RST;
            cruise_p = CRUISE_PERIOD_RST;
            ms_step = MS_PER_STEP_RST;
            target = '0;
            under_m = '0;
            over_m = '0;
            dist_en = 1'b1;
            release_idle = 1'b0;
            step_q = 1'b0;
            dir_q = 1'b0;
            en_q = 1'b0;
            moving_q = 1'b0;
            stopped_q = 1'b0;
            done_q = 1'b0;
            manual_q = 1'b0;
            brake_q = 1'b0;
            err_q = ERR_NONE;
            timer_q = TIMER_RST;
            period_q = '0;
            half_q = '0;
            pos_q = '0;
            accel_mark = '0;
            ramp_ms = '0;
            errors = 0;
            n_requests = 0;
            n_checked = 0;
            n_done = 0;
            n_under = 0;
            n_over = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_START_PERIOD:    start_p = val[15:0];
                CFG_CRUISE_PERIOD:   cruise_p = val[15:0];
                CFG_MS_PER_STEP:     ms_step = val[15:0];
                CFG_TARGET_STEPS:    target = val;
                CFG_UNDERSTEP:       under_m = val;
                CFG_OVERSTEP:        over_m = val;
                CFG_DISTANCE_ENABLE: dist_en = val[0];
                CFG_FREE_STAY:       release_idle = val[0];
                default: ;
            endcase
        endfunction

        function void coast_stop();
            moving_q = 1'b0;
            stopped_q = 1'b1;
            if (release_idle) en_q = 1'b1;
        endfunction

        function void count_tick();
            if (!moving_q) begin
                timer_q = TIMER_RST;
            end else if (period_q != '0) begin
                if (timer_q >= period_q) begin
                    step_q = ~step_q;
                    half_q = half_q + 32'd1;
                    pos_q = dir_q ? pos_q + 32'd1 : pos_q - 32'd1;
                    timer_q = TIMER_RST;
                end else begin
                    timer_q = timer_q + 16'd1;
                end
            end
        endfunction

        // returns the move verdict: 1 once the move has completed
        function logic ramp_move(logic dir, logic [1:0] es, logic slow, logic [31:0] now);
            logic [31:0] floor_steps, decel_mark;
            logic [32:0] over_lim;
            if (manual_q || stopped_q || err_q != ERR_NONE) return 1'b0;
            if (done_q) return 1'b1;
            // end stop code three counts as a hit too
            if (es >= 2'd2) begin
                floor_steps = (under_m > target) ? '0 : target - under_m;
                if (dist_en && half_q < floor_steps) begin
                    coast_stop();
                    err_q = ERR_UNDERSTEP;
                    n_under++;
                    return 1'b0;
                end
                if (slow) brake_q = 1'b1;
                if (!slow || period_q > start_p) begin
                    coast_stop();
                    if (slow) brake_q = 1'b0;
                    done_q = 1'b1;
                    return 1'b1;
                end
            end
            if (dist_en) begin
                if (half_q >= target && es == 2'd0) begin
                    coast_stop();
                    done_q = 1'b1;
                    return 1'b1;
                end
                over_lim = {1'b0, target} + {1'b0, over_m};
                if ({1'b0, half_q} >= over_lim) begin
                    coast_stop();
                    err_q = ERR_OVERSTEP;
                    n_over++;
                    return 1'b0;
                end
            end
            if (!moving_q) begin
                dir_q = dir;
                en_q = 1'b0;
                period_q = start_p;
                moving_q = 1'b1;
            end
            // 33-bit compare, the ramp interval never wraps
            if ({1'b0, now} >= {1'b0, ramp_ms} + {17'd0, ms_step}) begin
                decel_mark = (accel_mark > target) ? '0 : target - accel_mark;
                if (period_q > cruise_p && (!dist_en || half_q < (target >> 1)) && !brake_q) begin
                    period_q = period_q - 16'd1;
                    accel_mark = half_q;
                end else if ((period_q < start_p && half_q > decel_mark && dist_en) || brake_q) begin
                    if (period_q != PERIOD_MAX) period_q = period_q + 16'd1;
                end
                ramp_ms = now;
            end
            if (ramp_ms > now) ramp_ms = now;
            return 1'b0;
        endfunction

        function void note_request(logic [2:0] act, logic dir, logic [1:0] es, logic slow,
                                   logic [31:0] now, logic [15:0] mp);
            result_t r;
            logic    verdict;
            n_requests++;
            case (act)
                ACT_TICK: count_tick();
                ACT_MANUAL: begin
                    manual_q = 1'b1;
                    moving_q = 1'b1;
                    dir_q = dir;
                    en_q = 1'b0;
                    period_q = mp;
                end
                ACT_STOP: coast_stop();
                ACT_REFRESH: begin
                    coast_stop();
                    done_q = 1'b0;
                    manual_q = 1'b0;
                    stopped_q = 1'b0;
                    brake_q = 1'b0;
                    half_q = '0;
                end
                ACT_CLEAR: err_q = ERR_NONE;
                ACT_ZERO: pos_q = '0;
                default: ;
            endcase
            if (act == ACT_MOVE) begin
                verdict = ramp_move(dir, es, slow, now);
                if (verdict) n_done++;
            end else begin
                verdict = done_q;
            end
            r.step_level = step_q;
            r.dir_level = dir_q;
            r.enable_level = en_q;
            r.finished = verdict;
            r.moving = moving_q;
            r.error_code = err_q;
            r.step_count = half_q;
            r.position = pos_q;
            r.period_now = period_q;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            check_field("step_level", want.step_level, got.step_level);
            check_field("dir_level", want.dir_level, got.dir_level);
            check_field("enable_level", want.enable_level, got.enable_level);
            check_field("finished", want.finished, got.finished);
            check_field("moving", want.moving, got.moving);
            check_field("error_code", want.error_code, got.error_code);
            check_field("step_count", want.step_count, got.step_count);
            check_field("position", want.position, got.position);
            check_field("period_now", want.period_now, got.period_now);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_action;
    logic        s_direction;
    logic [1:0]  s_endstop;
    logic        s_ramp_stop;
    logic [31:0] s_time_ms;
    logic [15:0] s_manual_period;
    logic        m_valid;
    logic        m_ready;
    logic        m_step_level;
    logic        m_dir_level;
    logic        m_enable_level;
    logic        m_finished;
    logic        m_moving;
    logic [1:0]  m_error_code;
    logic [31:0] m_step_count;
    logic signed [31:0] m_position;
    logic [15:0] m_period_now;

    ramp_scoreboard sb;
    int          burst_left = 0;
    int          items_sent = 0;
    int          hold_asks = 0;
    int          holds_served = 0;
    int          stall_cycles = 0;
    logic [31:0] now_ms = '0;

    stepper_ramp_step_generator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_direction     (s_direction),
        .s_endstop       (s_endstop),
        .s_ramp_stop     (s_ramp_stop),
        .s_time_ms       (s_time_ms),
        .s_manual_period (s_manual_period),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_level    (m_step_level),
        .m_dir_level     (m_dir_level),
        .m_enable_level  (m_enable_level),
        .m_finished      (m_finished),
        .m_moving        (m_moving),
        .m_error_code    (m_error_code),
        .m_step_count    (m_step_count),
        .m_position      (m_position),
        .m_period_now    (m_period_now)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // both channels are sampled here; the bench drives with nonblocking writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_action, s_direction, s_endstop, s_ramp_stop,
                                s_time_ms, s_manual_period);
            // concatenation follows the field order of result_t
            if (m_valid && m_ready)
                sb.check_result({m_step_level, m_dir_level, m_enable_level, m_finished,
                                 m_moving, m_error_code, m_step_count, m_position,
                                 m_period_now});
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("stepper_ramp_step_generator_tb: errors");
        $finish;
    end

    // result sink: stretches of steady, random and patterned ready, plus long hold-offs
    initial begin : sink
        int stretch, mode, k, n;
        m_ready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_asks != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                stretch = $urandom_range(10, 150);
                mode = $urandom_range(0, 3);
                k = $urandom_range(2, 6);
                n = 0;
                while (n < stretch && hold_asks == holds_served) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= (n % k == 0);
                        default: m_ready <= (n % k != 0);
                    endcase
                    n++;
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic send(input logic [2:0] act, input logic dir, input logic [1:0] es,
                        input logic slow, input logic [31:0] t, input logic [15:0] mp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_action <= act;
        s_direction <= dir;
        s_endstop <= es;
        s_ramp_stop <= slow;
        s_time_ms <= t;
        s_manual_period <= mp;
        do @(posedge aclk); while (!s_ready);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic send_with_noise(input logic [2:0] act);
        logic [31:0] a, b;
        a = $urandom;
        b = $urandom;
        send(act, a[0], a[2:1], a[3], b, a[31:16]);
    endtask

    // wait until every request has its result and the pipeline is empty
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic set_all(input logic [15:0] sp, input logic [15:0] cp, input logic [15:0] ms,
                           input logic [31:0] tgt, input logic [31:0] um,
                           input logic [31:0] om, input logic de, input logic fs);
        cfg_write(CFG_START_PERIOD, {16'd0, sp});
        cfg_write(CFG_CRUISE_PERIOD, {16'd0, cp});
        cfg_write(CFG_MS_PER_STEP, {16'd0, ms});
        cfg_write(CFG_TARGET_STEPS, tgt);
        cfg_write(CFG_UNDERSTEP, um);
        cfg_write(CFG_OVERSTEP, om);
        cfg_write(CFG_DISTANCE_ENABLE, {31'd0, de});
        cfg_write(CFG_FREE_STAY, {31'd0, fs});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic directed_checks();
        send(ACT_TICK, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_UNUSED, 1'b1, 2'd3, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send(ACT_ZERO, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_CLEAR, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        // zero target: the first move completes at once, then keeps reporting done
        send(ACT_MOVE, 1'b1, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MOVE, 1'b0, 2'd1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send(ACT_TICK, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        // stopped without refresh refuses moves
        send(ACT_STOP, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MOVE, 1'b1, 2'd0, 1'b0, 32'd5, 16'd0);
        send(ACT_REFRESH, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        // manual with zero period holds still
        send(ACT_MANUAL, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_TICK, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MANUAL, 1'b1, 2'd0, 1'b0, 32'd0, 16'd1);
        send(ACT_TICK, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_TICK, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MOVE, 1'b1, 2'd0, 1'b0, 32'd7, 16'd0);
        send(ACT_REFRESH, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MOVE, 1'b0, 2'd3, 1'b0, 32'hFFFF_FFFF, 16'd0);
        drain();
        set_all(16'd4, 16'd2, 16'd1, 32'd12, 32'd4, 32'd3, 1'b1, 1'b0);
        send(ACT_REFRESH, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        // hit well short of the target flags understep, further moves are refused
        send(ACT_MOVE, 1'b1, 2'd2, 1'b1, 32'd5, 16'd0);
        send(ACT_MOVE, 1'b1, 2'd0, 1'b0, 32'd6, 16'd0);
        send(ACT_CLEAR, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_REFRESH, 1'b0, 2'd0, 1'b0, 32'd0, 16'd0);
        send(ACT_MOVE, 1'b1, 2'd0, 1'b0, 32'd10, 16'd0);
        send(ACT_MANUAL, 1'b0, 2'd0, 1'b0, 32'd0, 16'hFFFF);
    endtask

    task automatic program_phase(input int p);
        case (p)
            0: set_all(16'd6, 16'd2, 16'd1, 32'd16, 32'd5, 32'd4, 1'b1, 1'b0);
            1: set_all(16'd3, 16'd1, 16'd2, 32'd24, 32'd30, 32'd0, 1'b1, 1'b1);
            2: set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b1, 1'b1);
            3: set_all(16'd1, 16'd1, 16'd1, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
            4: set_all(16'd8, 16'd3, 16'd3, 32'd20, 32'd10, 32'd8, 1'b0, 1'b1);
            5: set_all(16'd5, 16'd1, 16'd1, 32'd8, 32'd0, 32'd2, 1'b1, 1'b0);
            6: set_all(16'd2, 16'hFFFF, 16'd1, 32'd10, 32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
            default: set_all(16'($urandom_range(2, 10)), 16'($urandom_range(1, 12)),
                             16'($urandom_range(1, 4)), $urandom_range(4, 30),
                             $urandom_range(0, 40), $urandom_range(0, 10),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    // one move attempt: refresh, then mostly ticks and moves with a running clock
    task automatic run_sequence();
        int          len, pick, es_mode, i;
        logic        dir, slow;
        logic [1:0]  es;
        logic [31:0] rnd;
        send_with_noise(ACT_REFRESH);
        if ($urandom_range(0, 3) == 0) send_with_noise(ACT_CLEAR);
        if ($urandom_range(0, 7) == 0) send_with_noise(ACT_ZERO);
        if ($urandom_range(0, 3) == 0) now_ms = $urandom;
        dir = 1'($urandom_range(0, 1));
        slow = 1'($urandom_range(0, 1));
        es_mode = $urandom_range(0, 2);
        len = $urandom_range(10, 100);
        for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                send_with_noise(ACT_TICK);
            end else if (pick < 90) begin
                // the clock now and then steps backward
                if ($urandom_range(0, 19) == 0)
                    now_ms = now_ms - $urandom_range(1, 2 * sb.ms_step);
                else
                    now_ms = now_ms + $urandom_range(0, 2 * sb.ms_step);
                case (es_mode)
                    0: es = 2'd0;
                    1: es = (i > len / 2 && $urandom_range(0, 6) == 0) ?
                            2'($urandom_range(2, 3)) : 2'd1;
                    default: es = 2'($urandom_range(0, 3));
                endcase
                rnd = $urandom;
                send(ACT_MOVE, dir, es, slow, now_ms, rnd[15:0]);
            end else if (pick < 93) begin
                rnd = $urandom;
                send(ACT_MANUAL, rnd[0], rnd[2:1], rnd[3],
                     $urandom, ($urandom_range(0, 3) == 0) ? rnd[31:16] :
                     16'($urandom_range(0, 6)));
            end else if (pick < 95) begin
                send_with_noise(ACT_STOP);
            end else begin
                send_with_noise(3'($urandom_range(0, 7)));
            end
        end
    endtask

    initial begin : stimulus
        int phase_end, p;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_action = '0;
        s_direction = 1'b0;
        s_endstop = '0;
        s_ramp_stop = 1'b0;
        s_time_ms = '0;
        s_manual_period = '0;
        sb = new;
        sb.reset_all();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        directed_checks();
        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            program_phase(p);
            // long result hold-off while requests keep coming
            if (p == 1 || p == 5) hold_asks++;
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) run_sequence();
        end
        drain();

        $display("run: %0d requests over %0d register settings, %0d results compared",
                 sb.n_requests, NUM_PHASES + 2, sb.n_checked);
        $display("run: %0d completed moves, %0d understep, %0d overstep, %0d long hold-offs",
                 sb.n_done, sb.n_under, sb.n_over, holds_served);
        if (sb.errors == 0)
            $display("stepper_ramp_step_generator_tb: clean");
        else
            $display("stepper_ramp_step_generator_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_cfg_regs.sv
rtl/core/ssg_engine.sv
rtl/core/ssg_out_stage.sv
rtl/core/stepper_ramp_step_generator.sv
rtl/core/ssg_checker.sv
test/stepper_ramp_step_generator_tb.sv
